// ===== hw/rtl/lrx_pkg.sv =====
// ----------------------------------------------------------------------------
// lrx_pkg
// shared types, register indexes and arithmetic helpers of the crossover
// ----------------------------------------------------------------------------
package lrx_pkg;

	localparam int COEF_W = 25;
	localparam int ST_W   = 32;
	localparam int ACC_W  = 40;

	localparam logic [COEF_W-1:0] K_EVEN   = 25'd31000253;
	localparam logic [COEF_W-1:0] K_ODD    = 25'd12840725;
	localparam logic [COEF_W-1:0] COEF_ONE = 25'd16777216;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_LR2_GAIN,
		REG_FIRST_A1,
		REG_FIRST_A2,
		REG_FIRST_A3,
		REG_SECOND_A1,
		REG_SECOND_A2,
		REG_SECOND_A3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_DONE
	} cell_state_t;

	typedef struct packed {
		logic start;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic                        mode;
		logic [COEF_W-1:0]           g;
		logic [1:0][2:0][COEF_W-1:0] a;
	} coef_t;

	typedef struct packed {
		logic                   ch;
		logic signed [ST_W-1:0] low;
		logic signed [ST_W-1:0] high;
	} word_t;

	function automatic logic signed [ST_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = 40'sh007FFFFFFF;
		lo = -hi - 40'sd1;
		if (v > hi) begin
			return ST_W'(hi);
		end else if (v < lo) begin
			return ST_W'(lo);
		end
		return ST_W'(v);
	endfunction

endpackage

// ===== hw/rtl/lrx_if.sv =====
// ----------------------------------------------------------------------------
// lrx_if
// stream and configuration channels of the crossover
// ----------------------------------------------------------------------------
interface lrx_smp_if;
	logic               valid;
	logic               ready;
	logic               channel;
	logic signed [23:0] sample_in;
	modport source(output valid, channel, sample_in, input ready);
	modport sink(input valid, channel, sample_in, output ready);
endinterface

interface lrx_res_if;
	logic               valid;
	logic               ready;
	logic               channel_out;
	logic signed [23:0] low_band;
	logic signed [23:0] high_band;
	modport source(output valid, channel_out, low_band, high_band, input ready);
	modport sink(input valid, channel_out, low_band, high_band, output ready);
endinterface

interface lrx_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  idx;
	logic [24:0] data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/lrx_cell.sv =====
// ----------------------------------------------------------------------------
// lrx_cell
// one filter section: state of all channels, one shared rounding multiplier
// ----------------------------------------------------------------------------
module lrx_cell #(
	parameter int IDX      = 0,
	parameter int CHANNELS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrx_pkg::cell_ctl_t ctl,
	input  lrx_pkg::coef_t    coef,
	input  lrx_pkg::word_t    din,
	output lrx_pkg::word_t    dout,
	output logic              done
);
	import lrx_pkg::*;

	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SET = IDX % 2;
	localparam bit LR2_CELL = (IDX < 2);
	localparam logic [COEF_W-1:0] K = (SET == 1) ? K_ODD : K_EVEN;

	logic signed [ST_W-1:0] st0_q [CHANNELS];
	logic signed [ST_W-1:0] st1_q [CHANNELS];
	logic signed [ST_W-1:0] st2_q [CHANNELS];
	logic signed [ST_W-1:0] st3_q [CHANNELS];
	logic [CHANNELS-1:0]    vld_q;

	cell_state_t state_q, state_d;
	logic                   path_q, path_d;
	logic                   ch_q;
	logic [CW-1:0]          rd_idx, wr_idx;
	logic signed [ST_W-1:0] xl_q, xh_q, s0_q, s1_q, s2_q, s3_q, lo_q, hi_q;
	logic signed [35:0]     v3_q, v1_q;
	logic signed [37:0]     acc_q, v2_q;

	logic signed [ST_W-1:0]  x, sa, sb;
	logic signed [35:0]      opa;
	logic signed [25:0]      opb;
	logic signed [61:0]      prod, rnd;
	logic signed [37:0]      m;
	logic signed [ACC_W-1:0] lp, v2;

	assign rd_idx = CW'(din.ch);
	assign wr_idx = CW'(ch_q);

	assign x  = path_q ? xh_q : xl_q;
	assign sa = path_q ? s2_q : s0_q;
	assign sb = path_q ? s3_q : s1_q;

	always_comb begin
		opa = 36'(x) - 36'(sa);
		opb = signed'({1'b0, coef.g});
		if (coef.mode) begin
			unique case (state_q)
				ST_P0: begin
					opa = 36'(sa);
					opb = signed'({1'b0, coef.a[SET][0]});
				end
				ST_P1: begin
					opa = v3_q;
					opb = signed'({1'b0, coef.a[SET][1]});
				end
				ST_P2: begin
					opa = 36'(sa);
					opb = signed'({1'b0, coef.a[SET][1]});
				end
				ST_P3: begin
					opa = v3_q;
					opb = signed'({1'b0, coef.a[SET][2]});
				end
				ST_P4: begin
					opa = v1_q;
					opb = signed'({1'b0, K});
				end
				default: begin
					opa = 36'(sa);
					opb = signed'({1'b0, coef.a[SET][0]});
				end
			endcase
		end
	end

	assign prod = 62'(opa) * 62'(opb);
	assign rnd  = prod + 62'sd8388608;
	assign m    = signed'(rnd[61:24]);
	assign lp   = ACC_W'(m) + ACC_W'(sa);
	assign v2   = ACC_W'(acc_q) + ACC_W'(m);

	always_comb begin
		state_d = state_q;
		path_d  = path_q;
		unique case (state_q)
			ST_IDLE: begin
				path_d = 1'b0;
				if (ctl.start) begin
					state_d = (coef.mode || LR2_CELL) ? ST_P0 : ST_DONE;
				end
			end
			ST_P0: begin
				if (coef.mode) begin
					state_d = ST_P1;
				end else if (!path_q) begin
					path_d = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_P1: state_d = ST_P2;
			ST_P2: state_d = ST_P3;
			ST_P3: begin
				if (!path_q) begin
					path_d  = 1'b1;
					state_d = ST_P0;
				end else begin
					state_d = ST_P4;
				end
			end
			ST_P4:   state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			path_q  <= 1'b0;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			path_q  <= path_d;
			if (ctl.clear) begin
				vld_q <= '0;
			end else if (state_q == ST_DONE) begin
				vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					ch_q <= din.ch;
					xl_q <= din.low;
					xh_q <= din.high;
					lo_q <= din.low;
					hi_q <= din.high;
					s0_q <= vld_q[rd_idx] ? st0_q[rd_idx] : '0;
					s1_q <= vld_q[rd_idx] ? st1_q[rd_idx] : '0;
					s2_q <= vld_q[rd_idx] ? st2_q[rd_idx] : '0;
					s3_q <= vld_q[rd_idx] ? st3_q[rd_idx] : '0;
				end
			end
			ST_P0: begin
				if (coef.mode) begin
					v3_q  <= 36'(x) - 36'(sb);
					acc_q <= m;
				end else if (!path_q) begin
					s0_q <= sat32(lp + ACC_W'(m));
					lo_q <= sat32(lp);
				end else begin
					s2_q <= sat32(lp + ACC_W'(m));
					hi_q <= sat32(ACC_W'(x) - lp);
				end
			end
			ST_P1: v1_q  <= 36'(ACC_W'(acc_q) + ACC_W'(m));
			ST_P2: acc_q <= 38'(ACC_W'(sb) + ACC_W'(m));
			ST_P3: begin
				v2_q <= 38'(v2);
				if (!path_q) begin
					s0_q <= sat32((ACC_W'(v1_q) <<< 1) - ACC_W'(sa));
					s1_q <= sat32((v2 <<< 1) - ACC_W'(sb));
					lo_q <= sat32(v2);
				end else begin
					s2_q <= sat32((ACC_W'(v1_q) <<< 1) - ACC_W'(sa));
					s3_q <= sat32((v2 <<< 1) - ACC_W'(sb));
				end
			end
			ST_P4: hi_q <= sat32(ACC_W'(x) - ACC_W'(m) - ACC_W'(v2_q));
			ST_DONE: begin
				st0_q[wr_idx] <= s0_q;
				st1_q[wr_idx] <= s1_q;
				st2_q[wr_idx] <= s2_q;
				st3_q[wr_idx] <= s3_q;
			end
			default: begin
			end
		endcase
	end

	assign done      = (state_q == ST_DONE);
	assign dout.ch   = ch_q;
	assign dout.low  = lo_q;
	assign dout.high = hi_q;

endmodule

// ===== hw/rtl/linkwitz_riley_crossover.sv =====
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover
// two-band crossover, LR2 one-pole or LR8 state-variable chains
// ----------------------------------------------------------------------------
// smp carries one sample word of a numbered channel, res returns that
// channel's lowpass and highpass word, cfg writes the mode and coefficient
// registers (index 0 mode, 1 lr2 gain, 2..7 the two a1..a3 sets).
// the sample travels a row of SECTIONS cells, one after the other; each cell
// keeps the integrators of every channel and owns one rounding multiplier.
// per cell: LR8 runs four products for the low band, five for the high band
// and a write back; LR2 runs one product per band and a write back in the
// first two cells and only passes the word on in the rest. a channel at or
// above CHANNELS returns zeros without passing through the cells.
// one word is in flight at a time.
// a finished word waits in a holding register while res stalls; smp is ready
// again once it moves to the output register.
// reset sets the registers to their defaults and marks all state as zero;
// writing a new mode clears all state at once.
// ----------------------------------------------------------------------------
module linkwitz_riley_crossover #(
	parameter int CHANNELS    = 2,
	parameter int SECTIONS    = 4,
	parameter int SAMPLE_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	lrx_smp_if.sink   smp,
	lrx_res_if.source res,
	lrx_cfg_if.sink   cfg
);
	import lrx_pkg::*;

	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 40'sd1;

	function automatic logic signed [23:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > SMAX) begin
			r = SMAX;
		end else if (v < SMIN) begin
			r = SMIN;
		end
		return r[23:0];
	endfunction

	coef_t     coef_q;
	logic      clr_q, start_q, busy_q;
	logic      pend_q, oval_q;
	word_t     in_q;
	logic      pch_q, och_q;
	logic signed [23:0] plo_q, phi_q, olo_q, ohi_q;
	cell_ctl_t ctl [SECTIONS];
	word_t     w   [SECTIONS+1];
	logic      dn  [SECTIONS];
	logic      acc_in, oob, move;
	logic signed [ACC_W-1:0] hfin;

	assign cfg.ready = 1'b1;
	assign smp.ready = !busy_q;
	assign acc_in    = smp.valid && !busy_q;
	assign oob       = (32'(smp.channel) >= CHANNELS);
	assign move      = pend_q && (!oval_q || res.ready);

	assign w[0] = in_q;

	for (genvar i = 0; i < SECTIONS; i++) begin : g_cell
		assign ctl[i].start = (i == 0) ? start_q : dn[(i == 0) ? 0 : i - 1];
		assign ctl[i].clear = clr_q;
		lrx_cell #(.IDX(i), .CHANNELS(CHANNELS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl[i]), .coef(coef_q),
			.din(w[i]), .dout(w[i+1]), .done(dn[i])
		);
	end

	assign hfin = coef_q.mode ? ACC_W'(w[SECTIONS].high) : -ACC_W'(w[SECTIONS].high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.mode <= 1'b0;
			coef_q.g    <= '0;
			coef_q.a    <= {25'd0, 25'd0, COEF_ONE, 25'd0, 25'd0, COEF_ONE};
			clr_q       <= 1'b0;
			start_q     <= 1'b0;
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			oval_q      <= 1'b0;
		end else begin
			clr_q   <= 1'b0;
			start_q <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.idx))
					REG_MODE: begin
						if (cfg.data[0] != coef_q.mode) begin
							coef_q.mode <= cfg.data[0];
							clr_q       <= 1'b1;
						end
					end
					REG_LR2_GAIN:  coef_q.g       <= cfg.data;
					REG_FIRST_A1:  coef_q.a[0][0] <= cfg.data;
					REG_FIRST_A2:  coef_q.a[0][1] <= cfg.data;
					REG_FIRST_A3:  coef_q.a[0][2] <= cfg.data;
					REG_SECOND_A1: coef_q.a[1][0] <= cfg.data;
					REG_SECOND_A2: coef_q.a[1][1] <= cfg.data;
					REG_SECOND_A3: coef_q.a[1][2] <= cfg.data;
					default: begin
					end
				endcase
			end
			if (acc_in) begin
				busy_q <= 1'b1;
				if (oob) begin
					pend_q <= 1'b1;
				end else begin
					start_q <= 1'b1;
				end
			end
			if (dn[SECTIONS-1]) begin
				pend_q <= 1'b1;
			end
			if (move) begin
				pend_q <= 1'b0;
				busy_q <= 1'b0;
				oval_q <= 1'b1;
			end else if (res.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			in_q.ch   <= smp.channel;
			in_q.low  <= sat32(ACC_W'(sat_out(ACC_W'(smp.sample_in))));
			in_q.high <= sat32(ACC_W'(sat_out(ACC_W'(smp.sample_in))));
			pch_q     <= smp.channel;
			plo_q     <= '0;
			phi_q     <= '0;
		end
		if (dn[SECTIONS-1]) begin
			pch_q <= w[SECTIONS].ch;
			plo_q <= sat_out(ACC_W'(w[SECTIONS].low));
			phi_q <= sat_out(hfin);
		end
		if (move) begin
			och_q <= pch_q;
			olo_q <= plo_q;
			ohi_q <= phi_q;
		end
	end

	assign res.valid       = oval_q;
	assign res.channel_out = och_q;
	assign res.low_band    = olo_q;
	assign res.high_band   = ohi_q;

endmodule

// ===== verif/linkwitz_riley_crossover_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover_chk
// watches the sample, result and register channels of the crossover, keeps
// its own copy of registers and integrator state, predicts each result word
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module linkwitz_riley_crossover_chk (
	input  logic      clk,
	input  logic      arst_n,
	lrx_smp_if        smp,
	lrx_res_if        res,
	lrx_cfg_if        cfg,
	output int        errors,
	output int        pending
);
	import lrx_pkg::*;

	typedef struct {
		logic               ch;
		logic signed [23:0] low;
		logic signed [23:0] high;
	} band_pair_t;

	band_pair_t       band_q[$];
	logic             cur_mode;
	logic [24:0]      gain;
	logic [24:0]      coef[2][3];
	longint           lr2_st[2][4];
	longint           lr8_st[2][4][4];

	function automatic longint floor24(longint v);
		return v >>> 24;
	endfunction

	function automatic longint rmul(longint v, longint c);
		return floor24(v * c + 64'sd8388608);
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	task automatic clear_all();
		foreach (lr2_st[c, i]) lr2_st[c][i] = 0;
		foreach (lr8_st[c, s, i]) lr8_st[c][s][i] = 0;
	endtask

	function automatic band_pair_t crossover(logic ch, logic signed [23:0] smp_v);
		band_pair_t r;
		longint lo, hi, v, lp, a1, a2, a3, k, v1, v2, v3;
		r.ch = ch;
		lo = smp_v;
		hi = smp_v;
		if (!cur_mode) begin
			for (int i = 0; i < 2; i++) begin
				v = rmul(lo - lr2_st[ch][i], gain);
				lp = v + lr2_st[ch][i];
				lr2_st[ch][i] = clip(lp + v, 32);
				lo = clip(lp, 32);
			end
			for (int i = 2; i < 4; i++) begin
				v = rmul(hi - lr2_st[ch][i], gain);
				lp = v + lr2_st[ch][i];
				lr2_st[ch][i] = clip(lp + v, 32);
				hi = clip(hi - lp, 32);
			end
			hi = -hi;
		end else begin
			for (int s = 0; s < 4; s++) begin
				a1 = coef[s % 2][0];
				a2 = coef[s % 2][1];
				a3 = coef[s % 2][2];
				k = (s % 2) ? longint'(K_ODD) : longint'(K_EVEN);
				v3 = lo - lr8_st[ch][s][1];
				v1 = rmul(lr8_st[ch][s][0], a1) + rmul(v3, a2);
				v2 = lr8_st[ch][s][1] + rmul(lr8_st[ch][s][0], a2) + rmul(v3, a3);
				lr8_st[ch][s][0] = clip(2 * v1 - lr8_st[ch][s][0], 32);
				lr8_st[ch][s][1] = clip(2 * v2 - lr8_st[ch][s][1], 32);
				lo = clip(v2, 32);
				v3 = hi - lr8_st[ch][s][3];
				v1 = rmul(lr8_st[ch][s][2], a1) + rmul(v3, a2);
				v2 = lr8_st[ch][s][3] + rmul(lr8_st[ch][s][2], a2) + rmul(v3, a3);
				lr8_st[ch][s][2] = clip(2 * v1 - lr8_st[ch][s][2], 32);
				lr8_st[ch][s][3] = clip(2 * v2 - lr8_st[ch][s][3], 32);
				hi = clip(hi - rmul(v1, k) - v2, 32);
			end
		end
		r.low = 24'(clip(lo, 24));
		r.high = 24'(clip(hi, 24));
		return r;
	endfunction

	assign pending = band_q.size();

	always @(posedge clk or negedge arst_n) begin
		band_pair_t e;
		if (!arst_n) begin
			errors <= 0;
			band_q.delete();
			cur_mode = 1'b0;
			gain = '0;
			coef[0] = '{COEF_ONE, 25'd0, 25'd0};
			coef[1] = '{COEF_ONE, 25'd0, 25'd0};
			clear_all();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.idx))
					REG_MODE: begin
						if (cfg.data[0] != cur_mode) begin
							cur_mode = cfg.data[0];
							clear_all();
						end
					end
					REG_LR2_GAIN: gain = cfg.data;
					default: coef[(cfg.idx - 2) / 3][(cfg.idx - 2) % 3] = cfg.data;
				endcase
			end
			if (smp.valid && smp.ready)
				band_q.push_back(crossover(smp.channel, smp.sample_in));
			if (res.valid && res.ready) begin
				if (band_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected word ch=%0d low=%0d high=%0d",
							res.channel_out, res.low_band, res.high_band);
					errors <= errors + 1;
				end else begin
					e = band_q.pop_front();
					if (e.ch !== res.channel_out || e.low !== res.low_band
							|| e.high !== res.high_band) begin
						if (errors < 10)
							$display("mismatch exp ch=%0d low=%0d high=%0d got ch=%0d low=%0d high=%0d",
								e.ch, e.low, e.high,
								res.channel_out, res.low_band, res.high_band);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== verif/linkwitz_riley_crossover_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover_tb
// drives sample words and register writes into the crossover across LR2 and
// LR8 settings with random gaps and output stalls; the checker judges results
// ----------------------------------------------------------------------------
module linkwitz_riley_crossover_tb;
	import lrx_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	bit   hold_off = 1'b0;
	bit   driving_done = 1'b0;

	lrx_smp_if smp();
	lrx_res_if res();
	lrx_cfg_if cfg();

	linkwitz_riley_crossover dut (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res), .cfg(cfg));
	linkwitz_riley_crossover_chk chk (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res),
		.cfg(cfg), .errors(errors), .pending(pending));

	always #10 clk = ~clk;

	initial begin
		smp.valid = 1'b0;
		smp.channel = 1'b0;
		smp.sample_in = '0;
		cfg.valid = 1'b0;
		cfg.idx = '0;
		cfg.data = '0;
		res.ready = 1'b0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 4);
	endfunction

	always begin
		int g;
		@(posedge clk);
		if (hold_off) begin
			res.ready <= 1'b0;
		end else begin
			g = gap_len();
			if (g <= 1 || $urandom_range(0, 3) == 0) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_word(logic ch, logic signed [23:0] v, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			smp.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.channel <= ch;
		smp.sample_in <= v;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic drain();
		@(posedge clk);
		smp.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [24:0] d);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(0, 255)) - 24'sd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [24:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return 25'd0;
			1: return COEF_ONE;
			2: return 25'h1FFFFFF;
			default: return 25'($urandom_range(0, 16777216));
		endcase
	endfunction

	task automatic random_setting(bit m);
		write_reg(REG_LR2_GAIN, rand_coef());
		for (int i = 2; i < 8; i++) write_reg(cfg_idx_t'(i), rand_coef());
		write_reg(REG_MODE, 25'(m));
	endtask

	task automatic burst(int n);
		for (int i = 0; i < n; i++)
			send_word(1'($urandom_range(0, 1)), rand_sample(), 1'b1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: defaults, then extremes in both modes
		send_word(1'b0, 24'sh7FFFFF, 1'b0);
		send_word(1'b1, 24'sh800000, 1'b0);
		drain();
		write_reg(REG_LR2_GAIN, COEF_ONE);
		send_word(1'b0, 24'sh7FFFFF, 1'b0);
		send_word(1'b0, 24'sh7FFFFF, 1'b0);
		send_word(1'b1, 24'sh800000, 1'b0);
		send_word(1'b1, 24'sd0, 1'b0);
		drain();
		write_reg(REG_LR2_GAIN, 25'h1FFFFFF);
		send_word(1'b0, 24'sh800000, 1'b0);
		send_word(1'b0, 24'sh7FFFFF, 1'b0);
		drain();
		write_reg(REG_MODE, 25'd0);
		send_word(1'b0, 24'sd1, 1'b0);
		drain();
		write_reg(REG_FIRST_A1, 25'h1FFFFFF);
		write_reg(REG_FIRST_A2, 25'h1FFFFFF);
		write_reg(REG_FIRST_A3, 25'h1FFFFFF);
		write_reg(REG_SECOND_A1, 25'd0);
		write_reg(REG_SECOND_A2, COEF_ONE);
		write_reg(REG_SECOND_A3, 25'd8388608);
		write_reg(REG_MODE, 25'd1);
		send_word(1'b0, 24'sh7FFFFF, 1'b0);
		send_word(1'b1, 24'sh800000, 1'b0);
		send_word(1'b0, 24'sh800000, 1'b0);
		send_word(1'b1, 24'sh7FFFFF, 1'b0);
		drain();
		write_reg(REG_MODE, 25'd1);
		send_word(1'b0, 24'sd5, 1'b0);
		drain();
		write_reg(REG_MODE, 25'd0);
		send_word(1'b1, 24'sh555555, 1'b0);
		send_word(1'b1, 24'shAAAAAA, 1'b0);
		drain();

		// back pressure: output held off while words keep coming
		hold_off = 1'b1;
		fork
			burst(12);
			begin repeat (300) @(posedge clk); hold_off = 1'b0; end
		join
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			random_setting(ph % 2);
			burst(100);
			drain();
		end

		driving_done = 1'b1;
	end

	initial begin
		wait (driving_done);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#40ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lrx_pkg.sv
hw/rtl/lrx_if.sv
hw/rtl/lrx_cell.sv
hw/rtl/linkwitz_riley_crossover.sv
verif/linkwitz_riley_crossover_chk.sv
verif/linkwitz_riley_crossover_tb.sv
